>>> rtl/dsps_pkg.sv
package dsps_pkg;

   localparam int MAX_NODES    = 16;
   localparam int NODE_WIDTH   = $clog2(MAX_NODES);
   localparam int CNT_WIDTH    = $clog2(MAX_NODES + 1);
   localparam int WEIGHT_WIDTH = 16;
   localparam int DIST_WIDTH   = 24;
   localparam int ADDR_WIDTH   = 2 * NODE_WIDTH;

   localparam logic [DIST_WIDTH-1:0] DIST_INF = {DIST_WIDTH{1'b1}};
   localparam logic [CNT_WIDTH-1:0]  NUM_NODES_RESET = CNT_WIDTH'(MAX_NODES);

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic                    func;
      logic [3:0]              from_node;
      logic [3:0]              to_node;
      logic [WEIGHT_WIDTH-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [3:0]            path_node;
      logic                  path_found;
      logic [DIST_WIDTH-1:0] goal_distance;
      logic                  last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_PICK,
      ST_MARK,
      ST_RELAX_RD,
      ST_RELAX,
      ST_CHECK,
      ST_WALK,
      ST_EMIT,
      ST_NOTFOUND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic write_weight;
      logic load_query;
      logic init;
      logic scan_clear;
      logic scan_step;
      logic pick_step;
      logic mark;
      logic relax_step;
      logic walk_push;
      logic walk_start;
      logic emit_step;
      logic emit_start;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_end;
      logic round_end;
      logic best_inf;
      logic query_bad;
      logic goal_unreach;
      logic walk_end;
      logic emit_end;
   } status_type;

endpackage

>>> rtl/dsps_datapath.sv
module dsps_datapath
   import dsps_pkg::*;
(
   input  logic                 clock,
   input  cmd_type              cmd,
   input  req_type              req_word,
   input  logic [CNT_WIDTH-1:0] num_nodes,
   output status_type           status,
   output rsp_type              rsp_word
);

   logic [WEIGHT_WIDTH-1:0] weight_mem [MAX_NODES*MAX_NODES];
   logic [WEIGHT_WIDTH-1:0] weight_rd_ff;
   logic [ADDR_WIDTH-1:0]   rd_addr;

   logic [DIST_WIDTH-1:0] dist_ff [MAX_NODES];
   logic [NODE_WIDTH:0]   pred_ff [MAX_NODES];
   logic [MAX_NODES-1:0]  done_ff;
   logic [NODE_WIDTH-1:0] stack_ff [MAX_NODES];

   logic [NODE_WIDTH-1:0] src_ff, goal_ff, u_ff, cur_ff;
   logic [CNT_WIDTH-1:0]  n_ff, idx_ff, round_ff, depth_ff, emit_ff;
   logic [DIST_WIDTH-1:0] best_ff;
   logic [NODE_WIDTH-1:0] idx;
   logic [DIST_WIDTH:0]   sum;
   logic [DIST_WIDTH-1:0] cand;
   logic [CNT_WIDTH-1:0]  n_eff;

   assign idx = idx_ff[NODE_WIDTH-1:0];

   always_comb begin
      n_eff = num_nodes;
      if (num_nodes == '0) begin
         n_eff = CNT_WIDTH'(1);
      end else if (num_nodes > CNT_WIDTH'(MAX_NODES)) begin
         n_eff = CNT_WIDTH'(MAX_NODES);
      end
   end

   assign rd_addr = {u_ff, idx};
   assign sum     = {1'b0, dist_ff[u_ff]} + {{(DIST_WIDTH-WEIGHT_WIDTH+1){1'b0}}, weight_rd_ff};
   assign cand    = (sum >= {1'b0, DIST_INF}) ? DIST_INF : sum[DIST_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.write_weight) begin
         weight_mem[{req_word.from_node, req_word.to_node}] <= req_word.weight;
      end
      weight_rd_ff <= weight_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         src_ff  <= req_word.from_node;
         goal_ff <= req_word.to_node;
         n_ff    <= n_eff;
      end
      if (cmd.init) begin
         for (int i = 0; i < MAX_NODES; i++) begin
            dist_ff[i] <= (NODE_WIDTH'(i) == src_ff) ? '0 : DIST_INF;
            pred_ff[i] <= '1;
         end
         done_ff  <= '0;
         round_ff <= '0;
      end
      if (cmd.scan_clear) begin
         idx_ff  <= '0;
         best_ff <= DIST_INF;
         u_ff    <= '0;
      end
      if (cmd.scan_step) begin
         idx_ff <= idx_ff + CNT_WIDTH'(1);
      end
      if (cmd.pick_step && !done_ff[idx] && best_ff >= dist_ff[idx]) begin
         best_ff <= dist_ff[idx];
         u_ff    <= idx;
      end
      if (cmd.mark) begin
         done_ff[u_ff] <= 1'b1;
         round_ff      <= round_ff + CNT_WIDTH'(1);
         idx_ff        <= '0;
      end
      // weight_rd_ff holds the entry for idx_ff - 1
      if (cmd.relax_step && idx_ff != '0) begin
         if (!done_ff[idx - NODE_WIDTH'(1)] && weight_rd_ff != '0
             && dist_ff[idx - NODE_WIDTH'(1)] > cand) begin
            dist_ff[idx - NODE_WIDTH'(1)] <= cand;
            pred_ff[idx - NODE_WIDTH'(1)] <= {1'b0, u_ff};
         end
      end
      if (cmd.walk_start) begin
         cur_ff   <= goal_ff;
         depth_ff <= '0;
      end
      if (cmd.walk_push) begin
         stack_ff[depth_ff[NODE_WIDTH-1:0]] <= cur_ff;
         depth_ff <= depth_ff + CNT_WIDTH'(1);
         cur_ff   <= pred_ff[cur_ff][NODE_WIDTH-1:0];
      end
      // issued with the final push, so count that push too
      if (cmd.emit_start) begin
         emit_ff <= depth_ff + CNT_WIDTH'(1);
      end
      if (cmd.emit_step) begin
         emit_ff <= emit_ff - CNT_WIDTH'(1);
      end
   end

   always_comb begin
      status.scan_end     = (idx_ff >= n_ff);
      status.round_end    = (round_ff >= n_ff);
      status.best_inf     = (dist_ff[u_ff] == DIST_INF);
      status.query_bad    = ({1'b0, req_word.from_node} >= {1'b0, n_eff[NODE_WIDTH-1:0]}
                             && n_eff != CNT_WIDTH'(MAX_NODES))
                            || ({1'b0, req_word.to_node} >= {1'b0, n_eff[NODE_WIDTH-1:0]}
                             && n_eff != CNT_WIDTH'(MAX_NODES));
      status.goal_unreach = (goal_ff != src_ff) && pred_ff[goal_ff][NODE_WIDTH];
      status.walk_end     = (cur_ff == src_ff) || pred_ff[cur_ff][NODE_WIDTH]
                            || (depth_ff + CNT_WIDTH'(1) >= n_ff);
      status.emit_end     = (emit_ff == CNT_WIDTH'(1));
   end

   always_comb begin
      rsp_word.path_node     = stack_ff[emit_ff[NODE_WIDTH-1:0] - NODE_WIDTH'(1)];
      rsp_word.path_found    = 1'b1;
      rsp_word.goal_distance = dist_ff[goal_ff];
      rsp_word.last          = status.emit_end;
   end

endmodule

>>> rtl/dsps_control.sv
module dsps_control
   import dsps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_notfound,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      rsp_notfound = 1'b0;
      busy         = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == FUNC_WRITE) begin
                  cmd.write_weight = 1'b1;
               end else if (status.query_bad) begin
                  state_in = ST_NOTFOUND;
               end else begin
                  cmd.load_query = 1'b1;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            cmd.scan_clear = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (status.round_end) begin
               state_in = ST_CHECK;
            end else if (status.scan_end) begin
               state_in = ST_MARK;
            end else begin
               cmd.pick_step = 1'b1;
               cmd.scan_step = 1'b1;
            end
         end
         ST_MARK: begin
            cmd.mark = 1'b1;
            // every node left is unreachable, nothing more can change
            if (status.best_inf) begin
               state_in = ST_CHECK;
            end else begin
               state_in = ST_RELAX_RD;
            end
         end
         ST_RELAX_RD: begin
            cmd.scan_step = 1'b1;
            state_in = ST_RELAX;
         end
         ST_RELAX: begin
            cmd.relax_step = 1'b1;
            if (status.scan_end) begin
               cmd.scan_clear = 1'b1;
               state_in = ST_PICK;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_CHECK: begin
            cmd.walk_start = 1'b1;
            state_in = status.goal_unreach ? ST_NOTFOUND : ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_push = 1'b1;
            if (status.walk_end) begin
               cmd.emit_start = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_step = 1'b1;
               if (status.emit_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NOTFOUND: begin
            rsp_valid = 1'b1;
            rsp_notfound = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/dense_shortest_path_search.sv
// channel  | direction | word
// req      | in        | req_type: func, from_node, to_node, weight
// rsp      | out       | rsp_type: path_node, path_found, goal_distance, last
// csr      | in        | num_nodes, 5 bits
// a weight write is stored as it is taken; a query runs the pick and relax scans
// over the weight memory port, ending early once every node left is unreachable,
// then walks up to n nodes and sends one result word per cycle unless rsp stalls
// reset is synchronous; num_nodes returns to 16, the weight memory is not cleared
// a stalled rsp word holds; req is not taken while a query runs
module dense_shortest_path_search
   import dsps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [4:0] csr_data
);

   logic [CNT_WIDTH-1:0] num_nodes_ff;
   cmd_type    cmd;
   status_type status;
   rsp_type    dp_word;
   logic       notfound;
   logic       busy;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_nodes_ff <= NUM_NODES_RESET;
      end else if (csr_valid && csr_ready) begin
         num_nodes_ff <= CNT_WIDTH'(csr_data);
      end
   end

   dsps_control u_control (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_data.func),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_notfound (notfound),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy)
   );

   dsps_datapath u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .req_word  (req_data),
      .num_nodes (num_nodes_ff),
      .status    (status),
      .rsp_word  (dp_word)
   );

   always_comb begin
      rsp_data = dp_word;
      if (notfound) begin
         rsp_data.path_node     = '0;
         rsp_data.path_found    = 1'b0;
         rsp_data.goal_distance = DIST_INF;
         rsp_data.last          = 1'b1;
      end
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !busy) else $error("req taken while busy");
   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("rsp word while idle");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("req and rsp together");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import dsps_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [4:0] csr_data;

   dense_shortest_path_search dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // predictor state
   logic [WEIGHT_WIDTH-1:0] edge_weight [MAX_NODES*MAX_NODES];
   logic [DIST_WIDTH-1:0]   path_dist [MAX_NODES];
   int                      path_prev [MAX_NODES];
   bit                      path_done [MAX_NODES];
   logic [4:0]              node_count_reg;

   req_type pending_words[$];
   rsp_type expected_words[$];

   int errors;
   int cycles;
   int writes_seen;
   int queries_seen;
   int words_checked;
   int csr_writes;
   int burst_left;
   int gap_left;
   int ready_mode;
   int ready_left;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void queue_item(input req_type w);
      pending_words = {pending_words, w};
   endfunction

   function automatic void queue_expect(input rsp_type r);
      expected_words = {expected_words, r};
   endfunction

   function automatic rsp_type miss_word();
      rsp_type r;
      r.path_node = '0;
      r.path_found = 1'b0;
      r.goal_distance = DIST_INF;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void shortest_path(input req_type w);
      int n;
      int u;
      int cur;
      int depth;
      logic [DIST_WIDTH-1:0] best;
      logic [DIST_WIDTH:0] sum;
      logic [DIST_WIDTH-1:0] cand;
      int chain[$];
      rsp_type r;
      if (w.func == FUNC_WRITE) begin
         edge_weight[w.from_node * MAX_NODES + w.to_node] = w.weight;
         writes_seen++;
         return;
      end
      queries_seen++;
      n = node_count_reg;
      if (n < 1) n = 1;
      if (n > MAX_NODES) n = MAX_NODES;
      if (w.from_node >= n || w.to_node >= n) begin
         queue_expect(miss_word());
         return;
      end
      for (int i = 0; i < MAX_NODES; i++) begin
         path_dist[i] = DIST_INF;
         path_prev[i] = -1;
         path_done[i] = 1'b0;
      end
      path_dist[w.from_node] = '0;
      for (int k = 0; k < n; k++) begin
         best = DIST_INF;
         u = 0;
         for (int i = 0; i < n; i++) begin
            if (!path_done[i] && best >= path_dist[i]) begin
               best = path_dist[i];
               u = i;
            end
         end
         path_done[u] = 1'b1;
         if (path_dist[u] == DIST_INF) continue;
         for (int i = 0; i < n; i++) begin
            if (!path_done[i] && edge_weight[u * MAX_NODES + i] != 0) begin
               sum = path_dist[u] + edge_weight[u * MAX_NODES + i];
               cand = (sum >= DIST_INF) ? DIST_INF : sum[DIST_WIDTH-1:0];
               if (path_dist[i] > cand) begin
                  path_dist[i] = cand;
                  path_prev[i] = u;
               end
            end
         end
      end
      if (w.to_node != w.from_node && path_prev[w.to_node] < 0) begin
         queue_expect(miss_word());
         return;
      end
      depth = 0;
      cur = w.to_node;
      while (depth < n) begin
         chain.push_front(cur);
         depth++;
         if (cur == w.from_node) break;
         cur = path_prev[cur];
         if (cur < 0) break;
      end
      foreach (chain[k]) begin
         r.path_node = chain[k][3:0];
         r.path_found = 1'b1;
         r.goal_distance = path_dist[w.to_node];
         r.last = (k == chain.size() - 1);
         queue_expect(r);
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) shortest_path(req_data);
         if (req_valid && !req_ready) begin
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_words.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 9);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               errors++;
               if (errors <= 10) $display("tb: unexpected rsp word %p", rsp_data);
            end else begin
               rsp_type e;
               e = expected_words.pop_front();
               words_checked++;
               if (e.path_node !== rsp_data.path_node || e.path_found !== rsp_data.path_found
                   || e.goal_distance !== rsp_data.goal_distance
                   || e.last !== rsp_data.last) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("tb: mismatch expected node %0d found %0d dist %0d last %0d",
                              e.path_node, e.path_found, e.goal_distance, e.last);
                     $display("tb:          got node %0d found %0d dist %0d last %0d",
                              rsp_data.path_node, rsp_data.path_found,
                              rsp_data.goal_distance, rsp_data.last);
                  end
               end
            end
         end
         if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(1, 24);
         end
         ready_left--;
         rsp_ready <= (ready_mode == 0) ? 1'b1 :
                      (ready_mode == 1) ? 1'($urandom_range(0, 1)) : 1'b0;
      end
   end

   // csr
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
         node_count_reg = 5'd16;
      end else if (csr_valid && csr_ready) begin
         node_count_reg = csr_data;
         csr_writes++;
         csr_valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic req_type make_word(input bit fn, input int a, input int b, input int w);
      req_type r;
      r.func = fn;
      r.from_node = a[3:0];
      r.to_node = b[3:0];
      r.weight = w[15:0];
      return r;
   endfunction

   function automatic int rand_weight();
      case ($urandom_range(0, 5))
         0, 1: return 0;
         2: return $urandom_range(0, 65535);
         3: return 65535 - $urandom_range(0, 3);
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   task automatic drain();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_nodes(input logic [4:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock);
      while (csr_valid);
   endtask

   initial begin
      logic [4:0] settings[8];
      settings = '{5'd16, 5'd1, 5'd0, 5'd2, 5'd31, 5'd5, 5'd8, 5'd16};
      errors = 0;
      cycles = 0;
      writes_seen = 0;
      queries_seen = 0;
      words_checked = 0;
      csr_writes = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // fill the whole matrix so no search reads an unwritten weight
      for (int i = 0; i < MAX_NODES * MAX_NODES; i++)
         queue_item(make_word(FUNC_WRITE, i / 16, i % 16, rand_weight()));
      // directed words
      queue_item(make_word(FUNC_WRITE, 0, 15, 65535));
      queue_item(make_word(FUNC_WRITE, 15, 0, 1));
      queue_item(make_word(FUNC_WRITE, 3, 7, 0));
      queue_item(make_word(FUNC_QUERY, 0, 15, 65535));
      queue_item(make_word(FUNC_QUERY, 15, 0, 0));
      queue_item(make_word(FUNC_QUERY, 7, 7, 0));
      queue_item(make_word(FUNC_QUERY, 3, 7, 12345));
      queue_item(make_word(FUNC_QUERY, 0, 0, 0));
      drain();

      foreach (settings[p]) begin
         set_nodes((p == 6) ? 5'($urandom_range(1, 16)) : settings[p]);
         if (p == 1) queue_item(make_word(FUNC_QUERY, 0, 1, 0));
         for (int k = 0; k < 7; k++) begin
            if ($urandom_range(0, 2) == 0)
               queue_item(make_word(FUNC_WRITE, $urandom_range(0, 15),
                                    $urandom_range(0, 15), rand_weight()));
            else
               queue_item(make_word(FUNC_QUERY, $urandom_range(0, 15),
                                    $urandom_range(0, 15),
                                    $urandom_range(0, 65535)));
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("tb: %0d weight writes, %0d searches, %0d result words checked",
               writes_seen, queries_seen, words_checked);
      $display("tb: %0d node count settings, %0d mismatches", csr_writes, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
